### design/kcub_pkg.sv
// Shared types and constants for the k-core upper-bound iteration block.
// Depends on nothing; used by kcub_apb_regs and kcore_upper_bound_iteration.
package kcub_pkg;

  // Default sizes of the on-chip stores
  localparam int unsigned DEF_MAX_VERTICES = 1024;
  localparam int unsigned DEF_MAX_ENTRIES  = 8192;
  localparam int unsigned DEF_MAX_DEGREE   = 1023;

  // Fixed field widths
  localparam int unsigned VERT_W  = 10;
  localparam int unsigned VCNT_W  = 11;
  localparam int unsigned BOUND_W = 10;
  localparam int unsigned PASS_W  = 16;
  localparam int unsigned HIST_DEPTH = 1 << BOUND_W;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_MAX_CORE = 1'b0;
  localparam logic [BOUND_W-1:0] MAX_CORE_RESET = 10'd1023;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [VERT_W-1:0] source_vertex;
    logic [VERT_W-1:0] neighbor_vertex;
    logic [VERT_W-1:0] query_vertex;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BOUND_W-1:0] core_value;
    logic [PASS_W-1:0]  pass_count;
    logic [VCNT_W-1:0]  vertex_count;
  } rsp_t;

endpackage

### design/kcub_apb_regs.sv
// APB-style configuration register file: holds the max_core cap.
// Depends on kcub_pkg.
module kcub_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kcub_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [kcub_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kcub_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [kcub_pkg::BOUND_W-1:0]       max_core_o
);
  import kcub_pkg::*;

  logic [BOUND_W-1:0] max_core_q;
  logic               wr_en;
  logic               hit;

  assign pready = 1'b1;
  // Register index is the word address
  assign hit    = (paddr[2] == REG_MAX_CORE) && (paddr[1:0] == 2'b00);
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_CORE);

  // Hold the cap, update on a completed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_core_q <= MAX_CORE_RESET;
    end else if (wr_en) begin
      max_core_q <= pwdata[BOUND_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit || (paddr[2] == REG_MAX_CORE)) begin
      prdata = APB_DATA_W'(max_core_q);
    end
  end

  assign max_core_o = max_core_q;

endmodule

### design/kcore_upper_bound_iteration.sv
// K-core decomposition by repeated in-place upper-bound sweeps over on-chip memories.
// Load: one request per cycle unless the result is stalled, result in the next cycle.
// Query: bound read, returned from S_QRY once the result slot frees. Clear: registered
// result, then S_CLR zeroes degrees, input stalled. Run: init sweep, passes until no bound drops
//   (stale vertices count neighbors, scan levels, lower neighbor supports on a drop), best bound.
// One request at a time. Reset runs the clearing pass; max_core 1023.
module kcore_upper_bound_iteration #(
  parameter int unsigned MAX_VERTICES = kcub_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_ENTRIES  = kcub_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned MAX_DEGREE   = kcub_pkg::DEF_MAX_DEGREE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_stall_o,
  input  kcub_pkg::req_t                  req_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_stall_i,
  output kcub_pkg::rsp_t                  rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kcub_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kcub_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kcub_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import kcub_pkg::*;

  localparam int unsigned VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SW = ((DW > BOUND_W) ? DW : BOUND_W) + 2;
  localparam logic [EA:0] ENT_MAX = (EA+1)'(MAX_ENTRIES);
  localparam logic [VA-1:0] V_LAST = VA'(MAX_VERTICES - 1);

  // Sequencer codes
  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_QRY      = 5'd2;
  localparam logic [4:0] S_INIT_RD  = 5'd3;
  localparam logic [4:0] S_INIT_WR  = 5'd4;
  localparam logic [4:0] S_PASS     = 5'd5;
  localparam logic [4:0] S_V_RD     = 5'd6;
  localparam logic [4:0] S_V_CHK    = 5'd7;
  localparam logic [4:0] S_H_CLR    = 5'd8;
  localparam logic [4:0] S_N_ADJ    = 5'd9;
  localparam logic [4:0] S_N_BND    = 5'd10;
  localparam logic [4:0] S_N_HRD    = 5'd11;
  localparam logic [4:0] S_N_HWR    = 5'd12;
  localparam logic [4:0] S_SCAN_RD  = 5'd13;
  localparam logic [4:0] S_SCAN_ACC = 5'd14;
  localparam logic [4:0] S_V_WR     = 5'd15;
  localparam logic [4:0] S_D_ADJ    = 5'd16;
  localparam logic [4:0] S_D_RD     = 5'd17;
  localparam logic [4:0] S_D_WR     = 5'd18;
  localparam logic [4:0] S_BEST_RD  = 5'd19;
  localparam logic [4:0] S_BEST_CMP = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  logic [BOUND_W-1:0] max_core;

  kcub_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_core_o (max_core)
  );

  // Control state
  logic [4:0]         state_q, state_d;
  logic [VA-1:0]      k_q, k_d;
  logic [VCNT_W-1:0]  u_q, u_d;
  logic [DW-1:0]      j_q, j_d;
  logic [BOUND_W-1:0] hk_q, hk_d;
  logic [BOUND_W-1:0] lvl_q, lvl_d;
  logic [BOUND_W-1:0] origin_q, origin_d;
  logic [DW-1:0]      deg_q, deg_d;
  logic [EA-1:0]      off_q, off_d;
  logic [DW-1:0]      acc_q, acc_d;
  logic [BOUND_W-1:0] nb_q, nb_d;
  logic [VCNT_W-1:0]  nv_q, nv_d;
  logic [BOUND_W-1:0] hidx_q, hidx_d;
  logic [BOUND_W-1:0] best_q, best_d;
  logic               changed_q, changed_d;
  logic [PASS_W-1:0]  passes_q, passes_d;
  logic [EA:0]        entries_q, entries_d;
  logic [VERT_W-1:0]  last_q, last_d;
  logic               src_valid_q, src_valid_d;
  logic [DW-1:0]      cur_deg_q, cur_deg_d;
  logic               computed_q, computed_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  // Memory ports
  logic [DW-1:0]      deg_mem [MAX_VERTICES];
  logic               deg_we;
  logic [VA-1:0]      deg_wa, deg_ra;
  logic [DW-1:0]      deg_wd, deg_rd;

  logic [EA-1:0]      off_mem [MAX_VERTICES];
  logic               off_we;
  logic [VA-1:0]      off_wa, off_ra;
  logic [EA-1:0]      off_wd, off_rd;

  logic [VERT_W-1:0]  adj_mem [MAX_ENTRIES];
  logic               adj_we;
  logic [EA-1:0]      adj_wa, adj_ra;
  logic [VERT_W-1:0]  adj_wd, adj_rd;

  logic [BOUND_W-1:0] bnd_mem [MAX_VERTICES];
  logic               bnd_we;
  logic [VA-1:0]      bnd_wa, bnd_ra;
  logic [BOUND_W-1:0] bnd_wd, bnd_rd;

  logic [SW-1:0]      sup_mem [MAX_VERTICES];
  logic               sup_we;
  logic [VA-1:0]      sup_wa, sup_ra;
  logic [SW-1:0]      sup_wd, sup_rd;

  logic [DW-1:0]      hist_mem [HIST_DEPTH];
  logic               hist_we;
  logic [BOUND_W-1:0] hist_wa, hist_ra;
  logic [DW-1:0]      hist_wd, hist_rd;

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end
  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_rd <= off_mem[off_ra];
  end
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[adj_ra];
  end
  always_ff @(posedge clk_i) begin
    if (bnd_we) bnd_mem[bnd_wa] <= bnd_wd;
    bnd_rd <= bnd_mem[bnd_ra];
  end
  always_ff @(posedge clk_i) begin
    if (sup_we) sup_mem[sup_wa] <= sup_wd;
    sup_rd <= sup_mem[sup_ra];
  end
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd <= hist_mem[hist_ra];
  end

  // Handshake
  logic              rsp_free;
  logic              req_acc;
  logic [VCNT_W-1:0] nv_cnt;

  assign rsp_free    = !rsp_valid_q || !rsp_stall_i;
  assign req_stall_o = !((state_q == S_IDLE) && rsp_free);
  assign req_acc     = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign nv_cnt      = src_valid_q ? (VCNT_W'(last_q) + VCNT_W'(1)) : '0;

  // Load checks and helpers
  logic              ld_reject, ld_same;
  logic [DW-1:0]     ld_deg;
  logic [VCNT_W-1:0] ld_nv;
  logic [DW-1:0]     acc_sum;
  logic [BOUND_W-1:0] init_bound;
  logic [EA-1:0]     adj_addr;

  always_comb begin
    ld_same   = src_valid_q && (req_i.source_vertex == last_q);
    ld_reject = (entries_q >= ENT_MAX)
             || (32'(req_i.source_vertex) >= MAX_VERTICES)
             || (32'(req_i.neighbor_vertex) >= MAX_VERTICES)
             || (src_valid_q && (req_i.source_vertex < last_q))
             || (ld_same && (32'(cur_deg_q) >= MAX_DEGREE));
    ld_deg    = ld_same ? (cur_deg_q + DW'(1)) : DW'(1);
    ld_nv     = VCNT_W'(req_i.source_vertex) + VCNT_W'(1);
    acc_sum   = acc_q + hist_rd;
    adj_addr  = off_q + EA'(j_q);
    init_bound = (32'(deg_rd) < 32'(max_core)) ? BOUND_W'(deg_rd) : max_core;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    u_d         = u_q;
    j_d         = j_q;
    hk_d        = hk_q;
    lvl_d       = lvl_q;
    origin_d    = origin_q;
    deg_d       = deg_q;
    off_d       = off_q;
    acc_d       = acc_q;
    nb_d        = nb_q;
    nv_d        = nv_q;
    hidx_d      = hidx_q;
    best_d      = best_q;
    changed_d   = changed_q;
    passes_d    = passes_q;
    entries_d   = entries_q;
    last_d      = last_q;
    src_valid_d = src_valid_q;
    cur_deg_d   = cur_deg_q;
    computed_d  = computed_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;

    deg_we = 1'b0;  deg_wa = '0;  deg_wd = '0;  deg_ra = '0;
    off_we = 1'b0;  off_wa = '0;  off_wd = '0;  off_ra = '0;
    adj_we = 1'b0;  adj_wa = '0;  adj_wd = '0;  adj_ra = '0;
    bnd_we = 1'b0;  bnd_wa = '0;  bnd_wd = '0;  bnd_ra = '0;
    sup_we = 1'b0;  sup_wa = '0;  sup_wd = '0;  sup_ra = '0;
    hist_we = 1'b0; hist_wa = '0; hist_wd = '0; hist_ra = '0;

    unique case (state_q)
      // Zero the degree memory one entry a cycle
      S_CLR: begin
        deg_we = 1'b1;
        deg_wa = k_q;
        deg_wd = '0;
        k_d    = k_q + VA'(1);
        if (k_q == V_LAST) begin
          k_d     = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_acc) begin
          rsp_d.status       = ST_OK;
          rsp_d.core_value   = '0;
          rsp_d.pass_count   = passes_q;
          rsp_d.vertex_count = nv_cnt;
          unique case (req_i.command)
            CMD_LOAD: begin
              rsp_valid_d = 1'b1;
              if (ld_reject) begin
                rsp_d.status = ST_REJECT;
              end else begin
                adj_we = 1'b1;
                adj_wa = EA'(entries_q);
                adj_wd = req_i.neighbor_vertex;
                deg_we = 1'b1;
                deg_wa = VA'(req_i.source_vertex);
                deg_wd = ld_deg;
                if (!ld_same) begin
                  off_we = 1'b1;
                  off_wa = VA'(req_i.source_vertex);
                  off_wd = EA'(entries_q);
                end
                entries_d   = entries_q + (EA+1)'(1);
                cur_deg_d   = ld_deg;
                last_d      = req_i.source_vertex;
                src_valid_d = 1'b1;
                computed_d  = 1'b0;
                rsp_d.vertex_count = ld_nv;
              end
            end
            CMD_RUN: begin
              nv_d    = nv_cnt;
              k_d     = '0;
              state_d = S_INIT_RD;
            end
            CMD_QUERY: begin
              if (!computed_q) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = ST_NOT_READY;
              end else if ((VCNT_W'(req_i.query_vertex) >= nv_cnt)
                            || (32'(req_i.query_vertex) >= MAX_VERTICES)) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = ST_RANGE;
              end else begin
                bnd_ra  = VA'(req_i.query_vertex);
                state_d = S_QRY;
              end
            end
            CMD_CLEAR: begin
              rsp_valid_d        = 1'b1;
              rsp_d.pass_count   = '0;
              rsp_d.vertex_count = '0;
              entries_d   = '0;
              last_d      = '0;
              src_valid_d = 1'b0;
              cur_deg_d   = '0;
              computed_d  = 1'b0;
              passes_d    = '0;
              k_d         = '0;
              state_d     = S_CLR;
            end
            default: ;
          endcase
        end
      end

      // Return the stored bound once the result slot frees
      S_QRY: begin
        if (rsp_free) begin
          rsp_valid_d      = 1'b1;
          rsp_d.core_value = bnd_rd;
          state_d          = S_IDLE;
        end
      end

      // Set every bound to min(degree, cap) and every support to zero
      S_INIT_RD: begin
        deg_ra  = k_q;
        state_d = S_INIT_WR;
      end
      S_INIT_WR: begin
        bnd_we = 1'b1;
        bnd_wa = k_q;
        bnd_wd = init_bound;
        sup_we = 1'b1;
        sup_wa = k_q;
        sup_wd = '0;
        k_d    = k_q + VA'(1);
        state_d = S_INIT_RD;
        if (k_q == V_LAST) begin
          k_d      = '0;
          passes_d = '0;
          state_d  = S_PASS;
        end
      end

      // Start a sweep
      S_PASS: begin
        if (passes_q != '1) begin
          passes_d = passes_q + PASS_W'(1);
        end
        changed_d = 1'b0;
        u_d       = '0;
        state_d   = S_V_RD;
      end

      S_V_RD: begin
        if (u_q >= nv_q) begin
          if (changed_q) begin
            state_d = S_PASS;
          end else begin
            u_d     = '0;
            best_d  = '0;
            state_d = S_BEST_RD;
          end
        end else begin
          bnd_ra  = VA'(u_q);
          sup_ra  = VA'(u_q);
          deg_ra  = VA'(u_q);
          off_ra  = VA'(u_q);
          state_d = S_V_CHK;
        end
      end

      // Skip a vertex whose support already covers its bound
      S_V_CHK: begin
        origin_d = bnd_rd;
        deg_d    = deg_rd;
        off_d    = off_rd;
        if ($signed(sup_rd) >= $signed(SW'(bnd_rd))) begin
          u_d     = u_q + VCNT_W'(1);
          state_d = S_V_RD;
        end else begin
          hk_d    = '0;
          state_d = S_H_CLR;
        end
      end

      // Clear histogram levels 0..origin
      S_H_CLR: begin
        hist_we = 1'b1;
        hist_wa = hk_q;
        hist_wd = '0;
        hk_d    = hk_q + BOUND_W'(1);
        if (hk_q == origin_q) begin
          j_d     = '0;
          state_d = S_N_ADJ;
        end
      end

      // Count neighbor bounds into the histogram, clipped at origin
      S_N_ADJ: begin
        if (j_q == deg_q) begin
          lvl_d   = origin_q;
          acc_d   = '0;
          nb_d    = '0;
          state_d = S_SCAN_RD;
        end else begin
          adj_ra  = adj_addr;
          state_d = S_N_BND;
        end
      end
      S_N_BND: begin
        bnd_ra  = VA'(adj_rd);
        state_d = S_N_HRD;
      end
      S_N_HRD: begin
        hidx_d  = (bnd_rd < origin_q) ? bnd_rd : origin_q;
        hist_ra = (bnd_rd < origin_q) ? bnd_rd : origin_q;
        state_d = S_N_HWR;
      end
      S_N_HWR: begin
        hist_we = 1'b1;
        hist_wa = hidx_q;
        hist_wd = hist_rd + DW'(1);
        j_d     = j_q + DW'(1);
        state_d = S_N_ADJ;
      end

      // Walk levels down from origin until the running count reaches the level or level 0 is reached
      S_SCAN_RD: begin
        if (lvl_q == '0) begin
          nb_d    = '0;
          state_d = S_V_WR;
        end else begin
          hist_ra = lvl_q;
          state_d = S_SCAN_ACC;
        end
      end
      S_SCAN_ACC: begin
        acc_d = acc_sum;
        if (32'(acc_sum) >= 32'(lvl_q)) begin
          nb_d    = lvl_q;
          state_d = S_V_WR;
        end else begin
          lvl_d   = lvl_q - BOUND_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      // Write back the new bound and support
      S_V_WR: begin
        bnd_we = 1'b1;
        bnd_wa = VA'(u_q);
        bnd_wd = nb_q;
        sup_we = 1'b1;
        sup_wa = VA'(u_q);
        sup_wd = SW'(acc_q);
        if (nb_q < origin_q) begin
          changed_d = 1'b1;
          j_d       = '0;
          state_d   = S_D_ADJ;
        end else begin
          u_d     = u_q + VCNT_W'(1);
          state_d = S_V_RD;
        end
      end

      // Drop support of neighbors whose bound lay in (nb, origin]
      S_D_ADJ: begin
        if (j_q == deg_q) begin
          u_d     = u_q + VCNT_W'(1);
          state_d = S_V_RD;
        end else begin
          adj_ra  = adj_addr;
          state_d = S_D_RD;
        end
      end
      S_D_RD: begin
        hidx_d  = '0;
        bnd_ra  = VA'(adj_rd);
        sup_ra  = VA'(adj_rd);
        k_d     = VA'(adj_rd);
        state_d = S_D_WR;
      end
      S_D_WR: begin
        if ((bnd_rd > nb_q) && (bnd_rd <= origin_q)) begin
          sup_we = 1'b1;
          sup_wa = k_q;
          sup_wd = sup_rd - SW'(1);
        end
        j_d     = j_q + DW'(1);
        state_d = S_D_ADJ;
      end

      // Find the largest bound
      S_BEST_RD: begin
        if (u_q >= nv_q) begin
          state_d = S_DONE;
        end else begin
          bnd_ra  = VA'(u_q);
          state_d = S_BEST_CMP;
        end
      end
      S_BEST_CMP: begin
        if (bnd_rd > best_q) begin
          best_d = bnd_rd;
        end
        u_d     = u_q + VCNT_W'(1);
        state_d = S_BEST_RD;
      end

      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d        = 1'b1;
          rsp_d.status       = ST_OK;
          rsp_d.core_value   = best_q;
          rsp_d.pass_count   = passes_q;
          rsp_d.vertex_count = nv_cnt;
          computed_d         = 1'b1;
          k_d                = '0;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      k_q         <= '0;
      u_q         <= '0;
      j_q         <= '0;
      hk_q        <= '0;
      lvl_q       <= '0;
      changed_q   <= 1'b0;
      passes_q    <= '0;
      entries_q   <= '0;
      last_q      <= '0;
      src_valid_q <= 1'b0;
      cur_deg_q   <= '0;
      computed_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      nv_q        <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      u_q         <= u_d;
      j_q         <= j_d;
      hk_q        <= hk_d;
      lvl_q       <= lvl_d;
      changed_q   <= changed_d;
      passes_q    <= passes_d;
      entries_q   <= entries_d;
      last_q      <= last_d;
      src_valid_q <= src_valid_d;
      cur_deg_q   <= cur_deg_d;
      computed_q  <= computed_d;
      rsp_valid_q <= rsp_valid_d;
      nv_q        <= nv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    origin_q <= origin_d;
    deg_q    <= deg_d;
    off_q    <= off_d;
    acc_q    <= acc_d;
    nb_q     <= nb_d;
    hidx_q   <= hidx_d;
    best_q   <= best_d;
    rsp_q    <= rsp_d;
  end

`ifndef SYNTHESIS
  a_entries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= ENT_MAX)
    else $error("entry count beyond store size");

  a_load_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.command == CMD_LOAD)) |=> rsp_valid_o)
    else $error("load request gave no result");

  a_scan_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_ACC) |-> ((lvl_q <= origin_q) && (lvl_q != '0)))
    else $error("histogram scan level out of range");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> req_stall_o)
    else $error("request taken while sequencer busy");
`endif

endmodule
